// ===== hdl/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, constants and Q16.16 helpers for the sparse accumulator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int GEN_W    = 16;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int FRAC_W   = 16;

  localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_DOT    = 3'd1,
    ACT_COMMIT = 3'd2,
    ACT_GATHER = 3'd3,
    ACT_CLEAR  = 3'd4
  } spa_action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GRD,
    S_GMUL,
    S_WB,
    S_CLEAR
  } spa_state_e;

  // Entry mark: an invalid mark is the "-1" mark, older than any generation.
  typedef struct packed {
    logic             valid;
    logic [GEN_W-1:0] gen;
  } spa_mark_t;

  typedef struct packed {
    logic rd;
    logic wr_mark;
    logic wr_value;
  } spa_ent_ctrl_t;

  // Q16.16 product rescale: arithmetic shift (floor), then saturate.
  function automatic logic signed [VALUE_W-1:0] scale_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-VALUE_W-FRAC_W:0] top;
    top = p[PROD_W-1:VALUE_W+FRAC_W-1];
    if ((&top) || !(|top)) begin
      return p[VALUE_W+FRAC_W-1:FRAC_W];
    end
    return p[PROD_W-1] ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_add(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? Q_MIN : Q_MAX;
    end
    return s[VALUE_W-1:0];
  endfunction

endpackage

// ===== hdl/spa_entry_mem.sv =====
// ----------------------------------------------------------------------------
// spa_entry_mem
// Accumulator entry store: one word per entry holding mark and value, with
// separate write enables for the two fields and a registered read port.
// ----------------------------------------------------------------------------
module spa_entry_mem
  import spa_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  spa_ent_ctrl_t             ctrl_i,
  input  logic [AW-1:0]             rd_addr_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  spa_mark_t                 wr_mark_i,
  input  logic signed [VALUE_W-1:0] wr_value_i,
  output spa_mark_t                 rd_mark_o,
  output logic signed [VALUE_W-1:0] rd_value_o
);

  localparam int MW = $bits(spa_mark_t);

  logic [MW+VALUE_W-1:0] mem_q [DEPTH];
  logic [MW+VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_mark) begin
      mem_q[wr_addr_i][MW+VALUE_W-1:VALUE_W] <= wr_mark_i;
    end
    if (ctrl_i.wr_value) begin
      mem_q[wr_addr_i][VALUE_W-1:0] <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_mark_o  = rdata_q[MW+VALUE_W-1:VALUE_W];
  assign rd_value_o = rdata_q[VALUE_W-1:0];

endmodule

// ===== hdl/sparse_accumulator.sv =====
// ----------------------------------------------------------------------------
// sparse_accumulator
// Sparse accumulator with generation marks, Q16.16 saturating arithmetic.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Add, dot term and dot commit pass through
// S_EXEC and S_WB: S_EXEC multiplies and, for add and commit, reads the
// entry; S_WB writes the entry back (a dot term only adds to the running
// sum) and takes the next beat. Gather steps through S_EXEC, S_GRD, S_GMUL
// and S_WB (read the touched list, read the entry, multiply by alpha, load
// the output register), and S_WB waits while the output register is full;
// a gather on an empty list yields no beat. The entry memory has one read and
// one write port. Clear rewrites every mark, one entry per cycle. After reset
// the same clearing pass runs before the first beat is taken.
// Indices at or above DEPTH change no entry. The touched list holds up to
// DEPTH indices; a new entry beyond that is still started but not listed.
// The gather that empties the list flags last and rewinds the list.
module sparse_accumulator
  import spa_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic [INDEX_W-1:0]        entry_index_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic signed [VALUE_W-1:0] factor_i,
  input  logic [GEN_W-1:0]          generation_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [INDEX_W-1:0]        out_index_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic                      last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);
  localparam int XW = AW + INDEX_W;
  localparam logic [TW-1:0] LIST_FULL = TW'(DEPTH);
  localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);

  spa_state_e state_q, state_d;

  // Beat fields held for the whole operation.
  logic [ACTION_W-1:0]       act_q;
  logic [INDEX_W-1:0]        idx_q;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] fac_q;
  logic [GEN_W-1:0]          gen_q;

  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [VALUE_W-1:0] dot_sum_q, dot_sum_d;
  logic                      dot_hit_q, dot_hit_d;
  logic [TW-1:0]             head_q, head_d, tail_q, tail_d, head_inc;
  logic [AW-1:0]             clr_cnt_q, clr_cnt_d;

  logic                      out_valid_q, out_valid_d, out_load;
  logic [INDEX_W-1:0]        out_index_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last_q, gather_last;

  // Touched list memory
  logic [INDEX_W-1:0] tl_mem [DEPTH];
  logic [INDEX_W-1:0] tl_rdata_q;
  logic               tl_re, tl_we;

  // Entry memory interface
  spa_ent_ctrl_t             ent_ctrl;
  logic [AW-1:0]             ent_rd_addr, ent_wr_addr;
  spa_mark_t                 ent_wr_mark, ent_rd_mark;
  logic signed [VALUE_W-1:0] ent_wr_value, ent_rd_value;

  logic [XW-1:0]             idx_x, pos_x;
  logic                      in_range, list_empty, list_full, older, apply;
  logic                      accept, wb_done, out_free;
  logic signed [VALUE_W-1:0] amount;

  assign idx_x      = XW'(idx_q);
  assign pos_x      = XW'(tl_rdata_q);
  assign in_range   = idx_x < XW'(DEPTH);
  assign list_empty = (head_q >= tail_q) || (head_q >= LIST_FULL);
  assign list_full  = tail_q == LIST_FULL;
  assign older      = !ent_rd_mark.valid || (ent_rd_mark.gen < gen_q);
  assign apply      = in_range && ((act_q == ACT_ADD) || dot_hit_q);
  assign amount     = (act_q == ACT_COMMIT) ? dot_sum_q : scale_sat(prod_q);
  assign head_inc   = head_q + TW'(1);
  assign gather_last = head_inc >= tail_q;

  // The output register frees itself in the same cycle it is taken.
  assign out_free = !out_valid_q || out_ready_i;
  assign wb_done  = (act_q != ACT_GATHER) || out_free;

  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_WB) && wb_done);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    prod_d       = prod_q;
    dot_sum_d    = dot_sum_q;
    dot_hit_d    = dot_hit_q;
    head_d       = head_q;
    tail_d       = tail_q;
    clr_cnt_d    = clr_cnt_q;
    out_load     = 1'b0;
    tl_re        = 1'b0;
    tl_we        = 1'b0;
    ent_ctrl     = '0;
    ent_rd_addr  = idx_x[AW-1:0];
    ent_wr_addr  = idx_x[AW-1:0];
    ent_wr_mark  = '{valid: 1'b1, gen: gen_q};
    ent_wr_value = amount;

    case (state_q)
      S_IDLE: begin
      end

      S_CLEAR: begin
        ent_ctrl.wr_mark = 1'b1;
        ent_wr_addr      = clr_cnt_q;
        ent_wr_mark      = '{valid: 1'b0, gen: '0};
        if (clr_cnt_q == CLR_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end

      S_EXEC: begin
        prod_d = val_q * fac_q;
        case (act_q)
          ACT_ADD, ACT_COMMIT: begin
            ent_ctrl.rd = 1'b1;
            state_d     = S_WB;
          end
          ACT_DOT: begin
            state_d = S_WB;
          end
          ACT_GATHER: begin
            if (list_empty) begin
              state_d = S_IDLE;
            end else begin
              tl_re   = 1'b1;
              state_d = S_GRD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_GRD: begin
        ent_ctrl.rd = 1'b1;
        ent_rd_addr = pos_x[AW-1:0];
        state_d     = S_GMUL;
      end

      S_GMUL: begin
        prod_d  = ent_rd_value * fac_q;
        state_d = S_WB;
      end

      S_WB: begin
        case (act_q)
          ACT_ADD, ACT_COMMIT: begin
            if (apply) begin
              // A stale mark restarts the entry and lists it once if the list has room.
              ent_ctrl.wr_mark  = older;
              ent_ctrl.wr_value = 1'b1;
              ent_wr_value      = older ? amount : sat_add(ent_rd_value, amount);
              if (older && !list_full) begin
                tl_we  = 1'b1;
                tail_d = tail_q + TW'(1);
              end
            end
            if (act_q == ACT_COMMIT) begin
              dot_sum_d = '0;
              dot_hit_d = 1'b0;
            end
          end
          ACT_DOT: begin
            dot_sum_d = sat_add(dot_sum_q, scale_sat(prod_q));
            dot_hit_d = 1'b1;
          end
          ACT_GATHER: begin
            if (out_free) begin
              out_load = 1'b1;
              if (gather_last) begin
                head_d = '0;
                tail_d = '0;
              end else begin
                head_d = head_inc;
              end
            end
          end
          default: begin
          end
        endcase
        if (wb_done) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (accept) begin
      clr_cnt_d = '0;
      state_d   = (action_i == ACT_CLEAR) ? S_CLEAR : S_EXEC;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      dot_sum_q   <= '0;
      dot_hit_q   <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      dot_sum_q   <= dot_sum_d;
      dot_hit_q   <= dot_hit_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      idx_q <= entry_index_i;
      val_q <= value_i;
      fac_q <= factor_i;
      gen_q <= generation_i;
    end
    prod_q <= prod_d;
    if (out_load) begin
      out_index_q <= tl_rdata_q;
      out_value_q <= scale_sat(prod_q);
      out_last_q  <= gather_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tl_we) begin
      tl_mem[tail_q[AW-1:0]] <= idx_q;
    end
    if (tl_re) begin
      tl_rdata_q <= tl_mem[head_q[AW-1:0]];
    end
  end

  spa_entry_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_entry_mem (
    .clk_i      (clk_i),
    .ctrl_i     (ent_ctrl),
    .rd_addr_i  (ent_rd_addr),
    .wr_addr_i  (ent_wr_addr),
    .wr_mark_i  (ent_wr_mark),
    .wr_value_i (ent_wr_value),
    .rd_mark_o  (ent_rd_mark),
    .rd_value_o (ent_rd_value)
  );

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign last_o      = out_last_q;

  // Beats are only taken when the sequencer is free or finishing.
  a_ready_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE || state_q == S_WB))
    else $error("beat taken while an operation is in flight");

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("touched list head passed tail");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= LIST_FULL)
    else $error("touched list tail beyond depth");

  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tl_we |-> !list_full)
    else $error("append into a full touched list");

  a_gather_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && act_q == ACT_GATHER && wb_done) |=> out_valid_o)
    else $error("finished gather produced no output beat");

endmodule
